// ----- rtl/core/round_trip_latency_statistics_assert.svh -----
`ifndef ROUND_TRIP_LATENCY_STATISTICS_ASSERT_SVH
`define ROUND_TRIP_LATENCY_STATISTICS_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define RTLS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RTLS_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/rtls_pkg.sv -----
package rtls_pkg;

	localparam int STORE_DEPTH = 2048;
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int PROD_W = CNT_W + 7;
	localparam int RECIP_SHIFT = 24;
	localparam logic [17:0] RECIP_100 = 18'd167773;
	localparam logic [6:0] PCT_95 = 7'd95;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_LOST = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [1:0] RK_SAMPLE = 2'd0;
	localparam logic [1:0] RK_SUMMARY = 2'd1;
	localparam logic [1:0] RK_REJECT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_MED,
		ST_P95,
		ST_P95W,
		ST_DIV
	} state_t;

endpackage

// ----- rtl/core/round_trip_latency_statistics.sv -----
// Channel   Handshake             Payload
// request   start, busy           kind, send_time, server_rx_time, server_tx_time,
//                                 client_rx_time
// result    result_valid (1 cyc)  result_kind, round_trip .. jitter_max
//
// Start and lost requests leave busy low, as does a sample that finds the store full.
// A sample answers in the cycle after it is taken, while busy stays high as the sorted store
// shifts each larger entry up by one, alternating read and compare states per entry.
// A done request holds busy through the store reads of ST_MED, ST_P95 and ST_P95W and a
// restoring divider that averages the three delay sums; with no samples it leaves busy low.
// Reset clears all statistics; the store needs no clearing. The receiver cannot stall.
module round_trip_latency_statistics (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  kind,
	input  logic [31:0]                 send_time,
	input  logic [31:0]                 server_rx_time,
	input  logic [31:0]                 server_tx_time,
	input  logic [31:0]                 client_rx_time,
	output logic                        result_valid,
	output logic [1:0]                  result_kind,
	output logic [31:0]                 round_trip,
	output logic [31:0]                 turnaround,
	output logic [31:0]                 uplink_delay,
	output logic [31:0]                 downlink_delay,
	output logic [rtls_pkg::CNT_W-1:0]  sample_count,
	output logic [15:0]                 lost_count,
	output logic [31:0]                 min_round_trip,
	output logic [31:0]                 max_round_trip,
	output logic [31:0]                 p95_round_trip,
	output logic [31:0]                 jitter_max
);
	import rtls_pkg::*;
	`include "round_trip_latency_statistics_assert.svh"

	state_t state_q, state_d;

	logic [31:0] store [STORE_DEPTH];
	logic [31:0] rd_q;
	logic        wr_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [31:0] wr_data;

	logic [CNT_W-1:0] count_q;
	logic [15:0] lost_q;
	logic [31:0] min_q, max_q, tsum_q, usum_q, dsum_q, prev_q, step_max_q;
	logic [31:0] ins_val_q;
	logic [CNT_W-1:0] idx_q;
	logic [PROD_W-1:0] prod_s1;
	logic [31:0] med_q;
	logic [31:0] p95_q;
	logic [31:0] quo_q [3];
	logic [CNT_W-1:0] rem_q [3];
	logic [4:0] div_cnt_q;

	logic accept, full, ins_req;
	logic [31:0] rtt, srv, up, down, step;
	logic [PROD_W+17:0] p95_prod;
	logic [IDX_W-1:0] p95_idx;
	logic [31:0] quo_d [3];
	logic [CNT_W-1:0] rem_d [3];

	logic            res_valid_q;
	logic [1:0]      res_kind_q;
	logic [31:0]     res_rtt_q, res_srv_q, res_up_q, res_down_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic [15:0]     res_lost_q;
	logic [31:0]     res_min_q, res_max_q, res_p95_q, res_jit_q;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign full = (count_q >= CNT_W'(STORE_DEPTH));
	assign ins_req = (kind == KIND_SAMPLE) && !full;

	assign rtt = (client_rx_time >= send_time) ? client_rx_time - send_time : 32'd0;
	assign srv = (server_tx_time >= server_rx_time) ? server_tx_time - server_rx_time : 32'd0;
	assign up = (server_rx_time >= send_time) ? server_rx_time - send_time : 32'd0;
	assign down = (client_rx_time >= server_tx_time) ? client_rx_time - server_tx_time : 32'd0;
	assign step = (count_q == '0) ? 32'd0 : ((rtt >= prev_q) ? rtt - prev_q : prev_q - rtt);

	assign p95_prod = prod_s1 * RECIP_100;
	assign p95_idx = p95_prod[RECIP_SHIFT +: IDX_W];

	always_comb begin
		logic [CNT_W:0] trial;
		for (int l = 0; l < 3; l++) begin
			trial = {rem_q[l], quo_q[l][31]};
			if (trial >= {1'b0, count_q}) begin
				rem_d[l] = CNT_W'(trial - {1'b0, count_q});
				quo_d[l] = {quo_q[l][30:0], 1'b1};
			end else begin
				rem_d[l] = trial[CNT_W-1:0];
				quo_d[l] = {quo_q[l][30:0], 1'b0};
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_SAMPLE && !full)
					state_d = ST_INS_RD;
				else if (accept && kind == KIND_DONE && count_q != '0)
					state_d = ST_MED;
			end
			ST_INS_RD: state_d = (idx_q == '0) ? ST_IDLE : ST_INS_CMP;
			ST_INS_CMP: state_d = (rd_q > ins_val_q) ? ST_INS_RD : ST_IDLE;
			ST_MED: state_d = ST_P95;
			ST_P95: state_d = ST_P95W;
			ST_P95W: state_d = ST_DIV;
			ST_DIV: if (div_cnt_q == 5'd31) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = ins_val_q;
		rd_addr = IDX_W'(idx_q - CNT_W'(1));
		unique case (state_q)
			ST_INS_RD: wr_en = (idx_q == '0);
			ST_INS_CMP: begin
				wr_en = 1'b1;
				if (rd_q > ins_val_q) wr_data = rd_q;
			end
			ST_MED: rd_addr = count_q[CNT_W-1:1];
			ST_P95: rd_addr = p95_idx;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) store[wr_addr] <= wr_data;
		rd_q <= store[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			lost_q <= '0;
			min_q <= '1;
			max_q <= '0;
			tsum_q <= '0;
			usum_q <= '0;
			dsum_q <= '0;
			prev_q <= '0;
			step_max_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid_q <= (accept && (kind == KIND_SAMPLE ||
				(kind == KIND_DONE && count_q == '0))) ||
				(state_q == ST_DIV && div_cnt_q == 5'd31);
			if (accept) begin
				unique case (kind)
					KIND_START: begin
						count_q <= '0;
						lost_q <= '0;
						min_q <= '1;
						max_q <= '0;
						tsum_q <= '0;
						usum_q <= '0;
						dsum_q <= '0;
						prev_q <= '0;
						step_max_q <= '0;
					end
					KIND_LOST: if (lost_q != 16'hFFFF) lost_q <= lost_q + 16'd1;
					KIND_SAMPLE: begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
							if (rtt < min_q) min_q <= rtt;
							if (rtt > max_q) max_q <= rtt;
							tsum_q <= tsum_q + srv;
							usum_q <= usum_q + up;
							dsum_q <= dsum_q + down;
							if (step > step_max_q) step_max_q <= step;
							prev_q <= rtt;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			ins_val_q <= rtt;
			idx_q <= count_q;
			div_cnt_q <= '0;
			res_lost_q <= lost_q;
			res_p95_q <= 32'd0;
			if (ins_req) begin
				res_kind_q <= RK_SAMPLE;
				res_rtt_q <= rtt;
				res_srv_q <= srv;
				res_up_q <= up;
				res_down_q <= down;
				res_cnt_q <= count_q + CNT_W'(1);
				res_min_q <= (rtt < min_q) ? rtt : min_q;
				res_max_q <= (rtt > max_q) ? rtt : max_q;
				res_jit_q <= (step > step_max_q) ? step : step_max_q;
			end else begin
				res_kind_q <= (kind == KIND_DONE) ? RK_SUMMARY : RK_REJECT;
				res_rtt_q <= 32'd0;
				res_srv_q <= 32'd0;
				res_up_q <= 32'd0;
				res_down_q <= 32'd0;
				res_cnt_q <= count_q;
				res_min_q <= (count_q == '0) ? 32'd0 : min_q;
				res_max_q <= (count_q == '0) ? 32'd0 : max_q;
				res_jit_q <= step_max_q;
			end
		end
		if (state_q == ST_INS_CMP && rd_q > ins_val_q) idx_q <= idx_q - CNT_W'(1);
		if (state_q == ST_MED) prod_s1 <= PROD_W'(count_q) * PROD_W'(PCT_95);
		if (state_q == ST_P95) med_q <= rd_q;
		if (state_q == ST_P95W) begin
			p95_q <= rd_q;
			quo_q[0] <= tsum_q;
			quo_q[1] <= usum_q;
			quo_q[2] <= dsum_q;
			for (int l = 0; l < 3; l++) rem_q[l] <= '0;
		end
		if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + 5'd1;
			for (int l = 0; l < 3; l++) begin
				quo_q[l] <= quo_d[l];
				rem_q[l] <= rem_d[l];
			end
			if (div_cnt_q == 5'd31) begin
				res_rtt_q <= med_q;
				res_p95_q <= p95_q;
				res_srv_q <= quo_d[0];
				res_up_q <= quo_d[1];
				res_down_q <= quo_d[2];
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind = res_kind_q;
	assign round_trip = res_rtt_q;
	assign turnaround = res_srv_q;
	assign uplink_delay = res_up_q;
	assign downlink_delay = res_down_q;
	assign sample_count = res_cnt_q;
	assign lost_count = res_lost_q;
	assign min_round_trip = res_min_q;
	assign max_round_trip = res_max_q;
	assign p95_round_trip = res_p95_q;
	assign jitter_max = res_jit_q;

	`RTLS_CHECK(a_count_bound, count_q <= CNT_W'(STORE_DEPTH), "sample count above store depth")
	`RTLS_CHECK(a_ins_idx, (state_q == ST_INS_RD || state_q == ST_INS_CMP) |-> idx_q < count_q,
		"insert index outside filled store")
	`RTLS_NEXT(a_full_reject, accept && kind == KIND_SAMPLE && full,
		result_valid && result_kind == RK_REJECT && !busy, "full store sample not rejected")
	`RTLS_NEXT(a_done_acts, accept && kind == KIND_DONE, busy || result_valid,
		"done request neither started nor answered")

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rtls_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [1:0]       rkind;
		logic [31:0]      trip;
		logic [31:0]      turn;
		logic [31:0]      up;
		logic [31:0]      down;
		logic [CNT_W-1:0] count;
		logic [15:0]      lost;
		logic [31:0]      min_trip;
		logic [31:0]      max_trip;
		logic [31:0]      p95;
		logic [31:0]      jitter;
	} latency_report_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       kind;
	logic [31:0]      send_time;
	logic [31:0]      server_rx_time;
	logic [31:0]      server_tx_time;
	logic [31:0]      client_rx_time;
	logic             result_valid;
	logic [1:0]       result_kind;
	logic [31:0]      round_trip;
	logic [31:0]      turnaround;
	logic [31:0]      uplink_delay;
	logic [31:0]      downlink_delay;
	logic [CNT_W-1:0] sample_count;
	logic [15:0]      lost_count;
	logic [31:0]      min_round_trip;
	logic [31:0]      max_round_trip;
	logic [31:0]      p95_round_trip;
	logic [31:0]      jitter_max;

	round_trip_latency_statistics u_dut (.*);

	// Statistics as the block should hold them.
	logic [31:0] sorted_trips[$];
	int unsigned lost_seen;
	logic [31:0] low_trip;
	logic [31:0] high_trip;
	logic [31:0] turn_sum;
	logic [31:0] up_sum;
	logic [31:0] down_sum;
	logic [31:0] last_trip;
	logic [31:0] widest_step;

	latency_report_t pending_reports[$];
	int error_count;
	int cycle_count;
	int idle_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** round_trip_latency_statistics: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	always @(posedge clk) begin
		latency_report_t want;
		if (arst_n && result_valid) begin
			if (pending_reports.size() == 0) begin
				report_mismatch("unexpected result", 32'(result_kind), 32'd0);
			end else begin
				want = pending_reports.pop_front();
				if (result_kind !== want.rkind)
					report_mismatch("result_kind", 32'(result_kind), 32'(want.rkind));
				if (round_trip !== want.trip) report_mismatch("round_trip", round_trip, want.trip);
				if (turnaround !== want.turn) report_mismatch("turnaround", turnaround, want.turn);
				if (uplink_delay !== want.up) report_mismatch("uplink_delay", uplink_delay, want.up);
				if (downlink_delay !== want.down)
					report_mismatch("downlink_delay", downlink_delay, want.down);
				if (sample_count !== want.count)
					report_mismatch("sample_count", 32'(sample_count), 32'(want.count));
				if (lost_count !== want.lost)
					report_mismatch("lost_count", 32'(lost_count), 32'(want.lost));
				if (min_round_trip !== want.min_trip)
					report_mismatch("min_round_trip", min_round_trip, want.min_trip);
				if (max_round_trip !== want.max_trip)
					report_mismatch("max_round_trip", max_round_trip, want.max_trip);
				if (p95_round_trip !== want.p95)
					report_mismatch("p95_round_trip", p95_round_trip, want.p95);
				if (jitter_max !== want.jitter) report_mismatch("jitter_max", jitter_max, want.jitter);
			end
		end
	end

	function automatic logic [31:0] clamped_gap(input logic [31:0] later, input logic [31:0] earlier);
		return (later >= earlier) ? later - earlier : 32'd0;
	endfunction

	task automatic clear_statistics();
		sorted_trips.delete();
		lost_seen = 0;
		low_trip = 32'hFFFF_FFFF;
		high_trip = '0;
		turn_sum = '0;
		up_sum = '0;
		down_sum = '0;
		last_trip = '0;
		widest_step = '0;
	endtask

	function automatic latency_report_t base_report(input logic [1:0] rk);
		latency_report_t r;
		r = '0;
		r.rkind = rk;
		r.count = CNT_W'(sorted_trips.size());
		r.lost = 16'(lost_seen);
		r.min_trip = sorted_trips.size() ? low_trip : 32'd0;
		r.max_trip = sorted_trips.size() ? high_trip : 32'd0;
		r.jitter = widest_step;
		return r;
	endfunction

	task automatic predict_statistics(input logic [1:0] k, input logic [31:0] t0,
			input logic [31:0] t1, input logic [31:0] t2, input logic [31:0] t3);
		latency_report_t r;
		logic [31:0] trip;
		logic [31:0] step;
		int n;
		int pos;
		int p95_idx;
		n = sorted_trips.size();
		case (k)
			KIND_START: clear_statistics();
			KIND_LOST: if (lost_seen < 65535) lost_seen++;
			KIND_SAMPLE: begin
				if (n >= STORE_DEPTH) begin
					pending_reports.push_back(base_report(RK_REJECT));
				end else begin
					trip = clamped_gap(t3, t0);
					if (trip < low_trip) low_trip = trip;
					if (trip > high_trip) high_trip = trip;
					turn_sum += clamped_gap(t2, t1);
					up_sum += clamped_gap(t1, t0);
					down_sum += clamped_gap(t3, t2);
					step = (n == 0) ? 32'd0 :
						(trip >= last_trip) ? trip - last_trip : last_trip - trip;
					if (step > widest_step) widest_step = step;
					last_trip = trip;
					pos = n;
					while (pos > 0 && sorted_trips[pos-1] > trip) pos--;
					sorted_trips.insert(pos, trip);
					r = base_report(RK_SAMPLE);
					r.trip = trip;
					r.turn = clamped_gap(t2, t1);
					r.up = clamped_gap(t1, t0);
					r.down = clamped_gap(t3, t2);
					pending_reports.push_back(r);
				end
			end
			default: begin
				r = base_report(RK_SUMMARY);
				if (n > 0) begin
					p95_idx = (n * 95) / 100;
					if (p95_idx >= n) p95_idx = n - 1;
					r.trip = sorted_trips[n/2];
					r.turn = turn_sum / n;
					r.up = up_sum / n;
					r.down = down_sum / n;
					r.p95 = sorted_trips[p95_idx];
				end
				pending_reports.push_back(r);
			end
		endcase
	endtask

	task automatic send_request(input logic [1:0] k, input logic [31:0] t0,
			input logic [31:0] t1, input logic [31:0] t2, input logic [31:0] t3);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		send_time <= t0;
		server_rx_time <= t1;
		server_tx_time <= t2;
		client_rx_time <= t3;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		predict_statistics(k, t0, t1, t2, t3);
	endtask

	task automatic send_sample(input logic [31:0] t0, input logic [31:0] up,
			input logic [31:0] turn, input logic [31:0] down);
		send_request(KIND_SAMPLE, t0, t0 + up, t0 + up + turn, t0 + up + turn + down);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		send_request(KIND_DONE, 0, 0, 0, 0);
		send_request(KIND_SAMPLE, 0, 0, 0, 0);
		send_request(KIND_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_SAMPLE, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
		send_request(KIND_SAMPLE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
		send_request(KIND_SAMPLE, 100, 50, 40, 90);
		send_request(KIND_SAMPLE, 10, 20, 30, 40);
		send_request(KIND_LOST, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
		send_request(KIND_LOST, 0, 0, 0, 0);
		send_request(KIND_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_SAMPLE, 5, 6, 7, 8);
		send_request(KIND_DONE, 0, 0, 0, 0);
		send_request(KIND_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_DONE, 0, 0, 0, 0);
		send_request(KIND_SAMPLE, 1000, 1300, 1400, 2000);
		send_request(KIND_DONE, 0, 0, 0, 0);
		send_request(KIND_START, 0, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_random_sessions(input int requests);
		int sent;
		int len;
		sent = 0;
		while (sent < requests) begin
			send_request(KIND_START, $urandom, $urandom, $urandom, $urandom);
			len = $urandom_range(30, 1);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(9))
					0: send_request(KIND_LOST, $urandom, $urandom, $urandom, $urandom);
					1: send_request(KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom);
					2: send_request(KIND_DONE, $urandom, $urandom, $urandom, $urandom);
					default: send_sample($urandom, $urandom_range(5000), $urandom_range(2000),
						$urandom_range(5000));
				endcase
			end
			send_request(KIND_DONE, $urandom, $urandom, $urandom, $urandom);
			sent += len + 2;
		end
		drain_results();
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_START;
		send_time = '0;
		server_rx_time = '0;
		server_tx_time = '0;
		client_rx_time = '0;
		clear_statistics();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		idle_pct = 0;
		test_random_sessions(310);
		idle_pct = 68;
		test_random_sessions(310);
		idle_pct = 31;
		test_random_sessions(310);
		repeat (100) @(posedge clk);

		if (error_count == 0 && pending_reports.size() == 0) begin
			$display("** round_trip_latency_statistics: PASSED **");
		end else begin
			$display("** round_trip_latency_statistics: FAILED **");
		end
		$finish;
	end
endmodule
